@@ src/ccms_pkg.sv @@
// ----------------------------------------------------------------------------
// ccms_pkg
// Shared types and constants of the cut-cycle motion sequencer.
// ----------------------------------------------------------------------------
package ccms_pkg;

  localparam int POSITION_BITS_DEF = 24;
  localparam int TIME_BITS_DEF     = 32;
  localparam int DRAW_BITS_DEF     = 16;

  localparam int MS_W      = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic [MS_W-1:0] DROPOFF_WAIT_RST = 16'd50;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_APPROACH     = 3'd0,
    CFG_CUTTING      = 3'd1,
    CFG_DROPOFF_MIN  = 3'd2,
    CFG_DROPOFF_MAX  = 3'd3,
    CFG_EARLY_REL    = 3'd4,
    CFG_HOME         = 3'd5,
    CFG_ESTOP_DELAY  = 3'd6,
    CFG_DROPOFF_WAIT = 3'd7
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_APPROACH = 3'd1,
    PH_CUTTING  = 3'd2,
    PH_DROPOFF  = 3'd3,
    PH_RETURN   = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    SPD_APPROACH = 3'd0,
    SPD_CUTTING  = 3'd1,
    SPD_DROPOFF  = 3'd2,
    SPD_RETURN   = 3'd3,
    SPD_HOMING   = 3'd4
  } speed_e;

  typedef enum logic [1:0] {
    CLAMP_NONE    = 2'd0,
    CLAMP_EXTEND  = 2'd1,
    CLAMP_RETRACT = 2'd2
  } clamp_e;

  typedef enum logic [1:0] {
    SEQ_IDLE  = 2'd0,
    SEQ_ENTRY = 2'd1,
    SEQ_PICK  = 2'd2,
    SEQ_EXEC  = 2'd3
  } seq_state_e;

endpackage

@@ src/ccms_in_if.sv @@
// ----------------------------------------------------------------------------
// ccms_in_if
// Tick channel: one control tick per item.
// ----------------------------------------------------------------------------
interface ccms_in_if #(
  parameter int POSITION_BITS = ccms_pkg::POSITION_BITS_DEF,
  parameter int TIME_BITS     = ccms_pkg::TIME_BITS_DEF,
  parameter int DRAW_BITS     = ccms_pkg::DRAW_BITS_DEF
);
  logic                            valid;
  logic                            ready;
  logic                            cycle_enter;
  logic [TIME_BITS-1:0]            now_ms;
  logic                            start_pressed;
  logic                            motor_running;
  logic signed [POSITION_BITS-1:0] motor_position;
  logic [DRAW_BITS-1:0]            random_draw;

  modport source (
    output valid, cycle_enter, now_ms, start_pressed, motor_running,
           motor_position, random_draw,
    input  ready
  );

  modport sink (
    input  valid, cycle_enter, now_ms, start_pressed, motor_running,
           motor_position, random_draw,
    output ready
  );
endinterface

@@ src/ccms_out_if.sv @@
// ----------------------------------------------------------------------------
// ccms_out_if
// Command channel: one motion command item per tick.
// ----------------------------------------------------------------------------
interface ccms_out_if #(
  parameter int POSITION_BITS = ccms_pkg::POSITION_BITS_DEF
);
  logic                     valid;
  logic                     ready;
  logic [2:0]               phase;
  logic                     move_valid;
  logic [POSITION_BITS-2:0] target_position;
  logic [2:0]               speed_select;
  logic                     accel_select;
  logic                     force_stop;
  logic [1:0]               clamp_command;
  logic                     warning_light;
  logic                     cycle_done;

  modport source (
    output valid, phase, move_valid, target_position, speed_select,
           accel_select, force_stop, clamp_command, warning_light, cycle_done,
    input  ready
  );

  modport sink (
    input  valid, phase, move_valid, target_position, speed_select,
           accel_select, force_stop, clamp_command, warning_light, cycle_done,
    output ready
  );
endinterface

@@ src/ccms_mod.sv @@
// ----------------------------------------------------------------------------
// ccms_mod
// Compare-and-subtract unit: dropoff pick lo + draw mod (hi - lo + 1),
// one draw bit per cycle.
// ----------------------------------------------------------------------------
module ccms_mod #(
  parameter int POSITION_BITS = ccms_pkg::POSITION_BITS_DEF,
  parameter int DRAW_BITS     = ccms_pkg::DRAW_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [POSITION_BITS-2:0] lo_i,
  input  logic [POSITION_BITS-2:0] hi_i,
  input  logic [DRAW_BITS-1:0]     draw_i,
  output logic                     done_o,
  output logic [POSITION_BITS-2:0] res_o
);
  import ccms_pkg::*;

  localparam int TGT_W = POSITION_BITS - 1;
  localparam int CNT_W = $clog2(DRAW_BITS + 1);

  logic                     busy_q, busy_d;
  logic                     done_q, done_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic [POSITION_BITS-1:0] div_q, div_d;
  logic [POSITION_BITS-1:0] rem_q, rem_d;
  logic [DRAW_BITS-1:0]     num_q, num_d;
  logic [TGT_W-1:0]         lo_q, lo_d;
  logic [TGT_W-1:0]         res_q, res_d;
  logic [POSITION_BITS:0]   trial;

  assign trial = {rem_q, num_q[DRAW_BITS-1]};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    div_d  = div_q;
    rem_d  = rem_q;
    num_d  = num_q;
    lo_d   = lo_q;
    res_d  = res_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DRAW_BITS);
      div_d  = POSITION_BITS'(hi_i) - POSITION_BITS'(lo_i) + POSITION_BITS'(1);
      rem_d  = '0;
      num_d  = draw_i;
      lo_d   = lo_i;
    end else if (busy_q) begin
      if (cnt_q != '0) begin
        // restoring step
        if (trial >= {1'b0, div_q}) begin
          rem_d = POSITION_BITS'(trial - {1'b0, div_q});
        end else begin
          rem_d = POSITION_BITS'(trial);
        end
        num_d = {num_q[DRAW_BITS-2:0], 1'b0};
        cnt_d = cnt_q - CNT_W'(1);
      end else begin
        res_d  = lo_q + TGT_W'(rem_q);
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
    rem_q <= rem_d;
    num_q <= num_d;
    lo_q  <= lo_d;
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

@@ src/ccms_seq.sv @@
// ----------------------------------------------------------------------------
// ccms_seq
// Tick sequencer: latches a tick, runs the phase logic over a few steps and
// loads the command output register.
// ----------------------------------------------------------------------------
module ccms_seq #(
  parameter int POSITION_BITS = ccms_pkg::POSITION_BITS_DEF,
  parameter int TIME_BITS     = ccms_pkg::TIME_BITS_DEF,
  parameter int DRAW_BITS     = ccms_pkg::DRAW_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  ccms_in_if.sink                       in_if,
  ccms_out_if.source                    out_if,
  input  logic [POSITION_BITS-2:0]      approach_pos_i,
  input  logic [POSITION_BITS-2:0]      cutting_pos_i,
  input  logic [POSITION_BITS-2:0]      dropoff_min_i,
  input  logic [POSITION_BITS-2:0]      dropoff_max_i,
  input  logic [POSITION_BITS-2:0]      early_rel_pos_i,
  input  logic [POSITION_BITS-2:0]      home_pos_i,
  input  logic [ccms_pkg::MS_W-1:0]     estop_delay_i,
  input  logic [ccms_pkg::MS_W-1:0]     dropoff_wait_i,
  output logic                          mod_start_o,
  output logic [DRAW_BITS-1:0]          mod_draw_o,
  input  logic                          mod_done_i,
  input  logic [POSITION_BITS-2:0]      mod_res_i
);
  import ccms_pkg::*;

  localparam int TGT_W = POSITION_BITS - 1;

  seq_state_e state_q, state_d;
  phase_e     phase_q, phase_d;
  logic       estop_q, estop_d;
  logic       released_q, released_d;
  logic       picked_q, picked_d;
  logic       wait_started_q, wait_started_d;
  logic       light_q, light_d;
  logic       accel_q, accel_d;
  logic       fstop_q, fstop_d;
  logic [TGT_W-1:0]     drop_tgt_q, drop_tgt_d;
  logic [TIME_BITS-1:0] cycle_start_q, cycle_start_d;
  logic [TIME_BITS-1:0] wait_start_q, wait_start_d;

  // latched tick
  logic                            enter_q;
  logic [TIME_BITS-1:0]            now_q;
  logic                            pressed_q;
  logic                            running_q;
  logic signed [POSITION_BITS-1:0] pos_q;
  logic [DRAW_BITS-1:0]            draw_q;

  // command output register
  logic             out_valid_q, out_valid_d;
  phase_e           out_phase_q, out_phase_d;
  logic             out_mv_q, out_mv_d;
  logic [TGT_W-1:0] out_tgt_q, out_tgt_d;
  speed_e           out_spd_q, out_spd_d;
  logic             out_accel_q, out_accel_d;
  logic             out_fstop_q, out_fstop_d;
  clamp_e           out_clamp_q, out_clamp_d;
  logic             out_light_q, out_light_d;
  logic             out_done_q, out_done_d;

  logic                 accept;
  logic                 out_free;
  logic                 entered;
  logic                 estop_hit;
  logic                 need_pick;
  logic                 mod_start;
  phase_e               phase_mid;
  logic [TIME_BITS-1:0] run_elapsed;
  logic [TIME_BITS-1:0] wait_elapsed;
  logic                 early_hit;
  logic                 rel_now;

  assign accept   = in_if.valid && in_if.ready;
  assign out_free = !out_valid_q || out_if.ready;
  assign in_if.ready = (state_q == SEQ_IDLE);

  // entry step terms
  assign entered     = (phase_q == PH_IDLE) && enter_q;
  assign run_elapsed = now_q - cycle_start_q;
  assign estop_hit   = !entered && (phase_q != PH_IDLE) && !estop_q && pressed_q &&
                       (run_elapsed > TIME_BITS'(estop_delay_i));
  assign phase_mid   = estop_hit ? PH_RETURN : (entered ? PH_APPROACH : phase_q);
  assign need_pick   = (phase_mid == PH_DROPOFF) && !picked_q;
  assign mod_start   = (state_q == SEQ_ENTRY) && need_pick &&
                       !(dropoff_max_i < dropoff_min_i);

  assign mod_start_o = mod_start;
  assign mod_draw_o  = draw_q;

  // execute step terms
  assign wait_elapsed = wait_started_q ? (now_q - wait_start_q) : '0;
  assign early_hit    = !released_q && !estop_q && !pos_q[POSITION_BITS-1] &&
                        (pos_q[TGT_W-1:0] >= early_rel_pos_i);
  assign rel_now      = released_q || early_hit;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SEQ_IDLE: begin
        if (accept) state_d = SEQ_ENTRY;
      end
      SEQ_ENTRY: begin
        state_d = mod_start ? SEQ_PICK : SEQ_EXEC;
      end
      SEQ_PICK: begin
        if (mod_done_i) state_d = SEQ_EXEC;
      end
      SEQ_EXEC: begin
        if (out_free) state_d = SEQ_IDLE;
      end
    endcase
  end

  // datapath and outputs
  always_comb begin
    phase_d        = phase_q;
    estop_d        = estop_q;
    released_d     = released_q;
    picked_d       = picked_q;
    wait_started_d = wait_started_q;
    light_d        = light_q;
    accel_d        = accel_q;
    fstop_d        = fstop_q;
    drop_tgt_d     = drop_tgt_q;
    cycle_start_d  = cycle_start_q;
    wait_start_d   = wait_start_q;

    out_valid_d = out_valid_q && !out_if.ready;
    out_phase_d = out_phase_q;
    out_mv_d    = out_mv_q;
    out_tgt_d   = out_tgt_q;
    out_spd_d   = out_spd_q;
    out_accel_d = out_accel_q;
    out_fstop_d = out_fstop_q;
    out_clamp_d = out_clamp_q;
    out_light_d = out_light_q;
    out_done_d  = out_done_q;

    unique case (state_q)
      SEQ_IDLE: begin
      end
      SEQ_ENTRY: begin
        fstop_d = estop_hit;
        if (entered) begin
          phase_d       = PH_APPROACH;
          estop_d       = 1'b0;
          released_d    = 1'b0;
          picked_d      = 1'b0;
          cycle_start_d = now_q;
          light_d       = 1'b1;
        end
        if (estop_hit) begin
          estop_d = 1'b1;
          phase_d = PH_RETURN;
          light_d = 1'b0;
        end
        // max below min picks max directly
        if (need_pick && (dropoff_max_i < dropoff_min_i)) begin
          drop_tgt_d = dropoff_max_i;
          picked_d   = 1'b1;
        end
      end
      SEQ_PICK: begin
        if (mod_done_i) begin
          drop_tgt_d = mod_res_i;
          picked_d   = 1'b1;
        end
      end
      SEQ_EXEC: begin
        if (out_free) begin
          out_mv_d    = 1'b0;
          out_tgt_d   = '0;
          out_spd_d   = SPD_APPROACH;
          out_fstop_d = fstop_q;
          out_clamp_d = fstop_q ? CLAMP_EXTEND : CLAMP_NONE;
          out_done_d  = 1'b0;
          unique case (phase_q)
            PH_APPROACH: begin
              out_mv_d    = 1'b1;
              out_clamp_d = CLAMP_EXTEND;
              accel_d     = 1'b1;
              out_spd_d   = SPD_APPROACH;
              out_tgt_d   = approach_pos_i;
              if (!running_q) begin
                accel_d = 1'b0;
                phase_d = PH_CUTTING;
              end
            end
            PH_CUTTING: begin
              out_mv_d  = 1'b1;
              out_spd_d = SPD_CUTTING;
              out_tgt_d = cutting_pos_i;
              if (!running_q) phase_d = PH_DROPOFF;
            end
            PH_DROPOFF: begin
              out_mv_d  = 1'b1;
              out_spd_d = SPD_DROPOFF;
              out_tgt_d = drop_tgt_q;
              if (early_hit) begin
                out_clamp_d = CLAMP_RETRACT;
                released_d  = 1'b1;
              end
              if (!running_q) begin
                if (!estop_q && !rel_now) out_clamp_d = CLAMP_RETRACT;
                if (!wait_started_q) begin
                  wait_started_d = 1'b1;
                  wait_start_d   = now_q;
                end
                if (wait_elapsed >= TIME_BITS'(dropoff_wait_i)) phase_d = PH_RETURN;
              end
            end
            PH_RETURN: begin
              out_mv_d  = 1'b1;
              out_tgt_d = home_pos_i;
              if (estop_q) begin
                out_spd_d = SPD_HOMING;
              end else begin
                out_clamp_d = CLAMP_RETRACT;
                out_spd_d   = SPD_RETURN;
              end
              if (!running_q) begin
                if (estop_q) out_clamp_d = CLAMP_RETRACT;
                phase_d        = PH_IDLE;
                out_done_d     = 1'b1;
                wait_started_d = 1'b0;
                estop_d        = 1'b0;
                released_d     = 1'b0;
                light_d        = 1'b0;
              end
            end
            default: begin
              phase_d = PH_IDLE;
            end
          endcase
          out_valid_d = 1'b1;
          out_phase_d = phase_d;
          out_accel_d = accel_d;
          out_light_d = light_d;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= SEQ_IDLE;
      phase_q        <= PH_IDLE;
      estop_q        <= 1'b0;
      released_q     <= 1'b0;
      picked_q       <= 1'b0;
      wait_started_q <= 1'b0;
      light_q        <= 1'b0;
      accel_q        <= 1'b0;
      fstop_q        <= 1'b0;
      drop_tgt_q     <= '0;
      cycle_start_q  <= '0;
      wait_start_q   <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      phase_q        <= phase_d;
      estop_q        <= estop_d;
      released_q     <= released_d;
      picked_q       <= picked_d;
      wait_started_q <= wait_started_d;
      light_q        <= light_d;
      accel_q        <= accel_d;
      fstop_q        <= fstop_d;
      drop_tgt_q     <= drop_tgt_d;
      cycle_start_q  <= cycle_start_d;
      wait_start_q   <= wait_start_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      enter_q   <= in_if.cycle_enter;
      now_q     <= in_if.now_ms;
      pressed_q <= in_if.start_pressed;
      running_q <= in_if.motor_running;
      pos_q     <= in_if.motor_position;
      draw_q    <= in_if.random_draw;
    end
    out_phase_q <= out_phase_d;
    out_mv_q    <= out_mv_d;
    out_tgt_q   <= out_tgt_d;
    out_spd_q   <= out_spd_d;
    out_accel_q <= out_accel_d;
    out_fstop_q <= out_fstop_d;
    out_clamp_q <= out_clamp_d;
    out_light_q <= out_light_d;
    out_done_q  <= out_done_d;
  end

  assign out_if.valid           = out_valid_q;
  assign out_if.phase           = out_phase_q;
  assign out_if.move_valid      = out_mv_q;
  assign out_if.target_position = out_tgt_q;
  assign out_if.speed_select    = out_spd_q;
  assign out_if.accel_select    = out_accel_q;
  assign out_if.force_stop      = out_fstop_q;
  assign out_if.clamp_command   = out_clamp_q;
  assign out_if.warning_light   = out_light_q;
  assign out_if.cycle_done      = out_done_q;

`ifndef SYNTHESIS
  a_accept_to_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == SEQ_ENTRY)
    else $error("accepted item did not enter the entry step");

  a_pick_follows_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_start |=> state_q == SEQ_PICK)
    else $error("dropoff pick started without waiting for the unit");

  a_result_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == SEQ_EXEC)
    else $error("result appeared outside the execute step");

  a_estop_in_return: assert property (@(posedge clk_i) disable iff (!rst_ni)
    estop_q |-> phase_q == PH_RETURN)
    else $error("emergency stop flag held outside the return phase");

  a_done_is_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_done_q) |-> out_phase_q == PH_IDLE)
    else $error("cycle end reported with a non-idle phase");
`endif

endmodule

@@ src/cut_cycle_motion_sequencer.sv @@
// ----------------------------------------------------------------------------
// cut_cycle_motion_sequencer
// Linear-axis cutting cycle sequencer: approach, cutting, dropoff, return.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                  contents
//  in_if     in   valid/ready                one control tick
//  out_if    out  valid/ready                one motion command item per tick
//  cfg       in   cfg_we_i, no back-pressure register index and write data
//
//  an item passes the accept, entry step and execute step; on the tick
//  that draws the dropoff target a pick step between entry and execute
//  waits for the one-bit-per-cycle remainder unit
//  the command register frees the input side while a result waits
//  a stalled output holds the sequencer in its execute step
//  reset clears all phase state; registers reset to zero, dropoff wait to 50
// ----------------------------------------------------------------------------
module cut_cycle_motion_sequencer #(
  parameter int POSITION_BITS = ccms_pkg::POSITION_BITS_DEF,
  parameter int TIME_BITS     = ccms_pkg::TIME_BITS_DEF,
  parameter int DRAW_BITS     = ccms_pkg::DRAW_BITS_DEF,
  localparam int CFG_W = (POSITION_BITS - 1 > ccms_pkg::MS_W) ?
                         POSITION_BITS - 1 : ccms_pkg::MS_W
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  ccms_in_if.sink                        in_if,
  ccms_out_if.source                     out_if,
  input  logic                           cfg_we_i,
  input  logic [ccms_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]               cfg_data_i
);
  import ccms_pkg::*;

  localparam int TGT_W = POSITION_BITS - 1;

  logic [TGT_W-1:0] approach_q, cutting_q, drop_min_q, drop_max_q, early_q, home_q;
  logic [MS_W-1:0]  estop_delay_q, drop_wait_q;

  logic                 mod_start;
  logic [DRAW_BITS-1:0] mod_draw;
  logic                 mod_done;
  logic [TGT_W-1:0]     mod_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      approach_q    <= '0;
      cutting_q     <= '0;
      drop_min_q    <= '0;
      drop_max_q    <= '0;
      early_q       <= '0;
      home_q        <= '0;
      estop_delay_q <= '0;
      drop_wait_q   <= DROPOFF_WAIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_APPROACH:     approach_q    <= cfg_data_i[TGT_W-1:0];
        CFG_CUTTING:      cutting_q     <= cfg_data_i[TGT_W-1:0];
        CFG_DROPOFF_MIN:  drop_min_q    <= cfg_data_i[TGT_W-1:0];
        CFG_DROPOFF_MAX:  drop_max_q    <= cfg_data_i[TGT_W-1:0];
        CFG_EARLY_REL:    early_q       <= cfg_data_i[TGT_W-1:0];
        CFG_HOME:         home_q        <= cfg_data_i[TGT_W-1:0];
        CFG_ESTOP_DELAY:  estop_delay_q <= cfg_data_i[MS_W-1:0];
        CFG_DROPOFF_WAIT: drop_wait_q   <= cfg_data_i[MS_W-1:0];
      endcase
    end
  end

  ccms_mod #(
    .POSITION_BITS (POSITION_BITS),
    .DRAW_BITS     (DRAW_BITS)
  ) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mod_start),
    .lo_i    (drop_min_q),
    .hi_i    (drop_max_q),
    .draw_i  (mod_draw),
    .done_o  (mod_done),
    .res_o   (mod_res)
  );

  ccms_seq #(
    .POSITION_BITS (POSITION_BITS),
    .TIME_BITS     (TIME_BITS),
    .DRAW_BITS     (DRAW_BITS)
  ) u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_if           (in_if),
    .out_if          (out_if),
    .approach_pos_i  (approach_q),
    .cutting_pos_i   (cutting_q),
    .dropoff_min_i   (drop_min_q),
    .dropoff_max_i   (drop_max_q),
    .early_rel_pos_i (early_q),
    .home_pos_i      (home_q),
    .estop_delay_i   (estop_delay_q),
    .dropoff_wait_i  (drop_wait_q),
    .mod_start_o     (mod_start),
    .mod_draw_o      (mod_draw),
    .mod_done_i      (mod_done),
    .mod_res_i       (mod_res)
  );

endmodule

@@ dv/cut_cycle_checker.sv @@
// ----------------------------------------------------------------------------
// cut_cycle_checker
// Watches the tick and command channels of the cut-cycle sequencer, keeps
// its own copy of the phase state and registers, predicts one command item
// per accepted tick and compares each accepted command in order.
// ----------------------------------------------------------------------------
module cut_cycle_checker
  import ccms_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  ccms_in_if               tick_ch,
  ccms_out_if              cmd_ch,
  input  logic             cfg_we_i,
  input  cfg_idx_e         cfg_idx_i,
  input  logic [22:0]      cfg_data_i,
  output int               fail_count_o,
  output int               pending_o,
  output int               checked_o,
  output int               cycles_done_o,
  output int               estops_o,
  output int               releases_o
);

  typedef struct packed {
    logic [2:0]  phase;
    logic        move_valid;
    logic [22:0] target;
    logic [2:0]  speed;
    logic        accel;
    logic        force_stop;
    logic [1:0]  clamp;
    logic        light;
    logic        done;
  } motion_cmd_t;

  // register copies
  logic [22:0] approach_pos, cut_pos, drop_min, drop_max, release_pos, home_pos;
  logic [15:0] estop_delay, drop_wait;

  // sequencer state
  phase_e      seq_phase;
  logic        estop_latched, released, target_drawn, wait_armed;
  logic        light_on, accel_reduced;
  logic [22:0] drop_target;
  logic [31:0] cycle_t0, wait_t0;

  motion_cmd_t expected_cmds[$];
  int mismatches, checked, cycles_done, estops, releases, pending;

  assign fail_count_o  = mismatches;
  assign pending_o     = pending;
  assign checked_o     = checked;
  assign cycles_done_o = cycles_done;
  assign estops_o      = estops;
  assign releases_o    = releases;

  task automatic advance_tick(input logic enter, input logic [31:0] now,
                              input logic pressed, input logic running,
                              input logic signed [23:0] pos, input logic [15:0] draw,
                              output motion_cmd_t c);
    logic [31:0] span, pick;
    c = '0;
    if (seq_phase == PH_IDLE && enter) begin
      seq_phase     = PH_APPROACH;
      estop_latched = 1'b0;
      released      = 1'b0;
      target_drawn  = 1'b0;
      cycle_t0      = now;
      light_on      = 1'b1;
    end
    if (seq_phase != PH_IDLE) begin
      if (!estop_latched && pressed && (now - cycle_t0) > {16'd0, estop_delay}) begin
        c.force_stop  = 1'b1;
        c.clamp       = CLAMP_EXTEND;
        estop_latched = 1'b1;
        seq_phase     = PH_RETURN;
        light_on      = 1'b0;
        estops++;
      end
      c.move_valid = 1'b1;
      case (seq_phase)
        PH_APPROACH: begin
          c.clamp       = CLAMP_EXTEND;
          accel_reduced = 1'b1;
          c.speed       = SPD_APPROACH;
          c.target      = approach_pos;
          if (!running) begin
            accel_reduced = 1'b0;
            seq_phase     = PH_CUTTING;
          end
        end
        PH_CUTTING: begin
          c.speed  = SPD_CUTTING;
          c.target = cut_pos;
          if (!running) seq_phase = PH_DROPOFF;
        end
        PH_DROPOFF: begin
          if (!target_drawn) begin
            if (drop_max < drop_min) begin
              drop_target = drop_max;
            end else begin
              span        = {9'd0, drop_max} - {9'd0, drop_min} + 32'd1;
              pick        = {9'd0, drop_min} + ({16'd0, draw} % span);
              drop_target = pick[22:0];
            end
            target_drawn = 1'b1;
          end
          c.speed  = SPD_DROPOFF;
          c.target = drop_target;
          // signed position against unsigned threshold
          if (!released && !estop_latched &&
              $signed({pos[23], pos}) >= $signed({2'b00, release_pos})) begin
            c.clamp  = CLAMP_RETRACT;
            released = 1'b1;
            releases++;
          end
          if (!running) begin
            if (!estop_latched && !released) c.clamp = CLAMP_RETRACT;
            if (!wait_armed) begin
              wait_armed = 1'b1;
              wait_t0    = now;
            end
            if ((now - wait_t0) >= {16'd0, drop_wait}) seq_phase = PH_RETURN;
          end
        end
        default: begin
          if (estop_latched) begin
            c.speed = SPD_HOMING;
          end else begin
            c.clamp = CLAMP_RETRACT;
            c.speed = SPD_RETURN;
          end
          c.target = home_pos;
          if (!running) begin
            if (estop_latched) c.clamp = CLAMP_RETRACT;
            seq_phase     = PH_IDLE;
            c.done        = 1'b1;
            wait_armed    = 1'b0;
            estop_latched = 1'b0;
            released      = 1'b0;
            light_on      = 1'b0;
            cycles_done++;
          end
        end
      endcase
    end
    c.phase = seq_phase;
    c.accel = accel_reduced;
    c.light = light_on;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    motion_cmd_t got, want;
    if (!rst_ni) begin
      approach_pos  = '0;
      cut_pos       = '0;
      drop_min      = '0;
      drop_max      = '0;
      release_pos   = '0;
      home_pos      = '0;
      estop_delay   = '0;
      drop_wait     = DROPOFF_WAIT_RST;
      seq_phase     = PH_IDLE;
      estop_latched = 1'b0;
      released      = 1'b0;
      target_drawn  = 1'b0;
      wait_armed    = 1'b0;
      light_on      = 1'b0;
      accel_reduced = 1'b0;
      drop_target   = '0;
      cycle_t0      = '0;
      wait_t0       = '0;
      expected_cmds.delete();
      mismatches    = 0;
      checked       = 0;
      cycles_done   = 0;
      estops        = 0;
      releases      = 0;
      pending       = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_APPROACH:     approach_pos = cfg_data_i;
          CFG_CUTTING:      cut_pos      = cfg_data_i;
          CFG_DROPOFF_MIN:  drop_min     = cfg_data_i;
          CFG_DROPOFF_MAX:  drop_max     = cfg_data_i;
          CFG_EARLY_REL:    release_pos  = cfg_data_i;
          CFG_HOME:         home_pos     = cfg_data_i;
          CFG_ESTOP_DELAY:  estop_delay  = cfg_data_i[15:0];
          CFG_DROPOFF_WAIT: drop_wait    = cfg_data_i[15:0];
          default: ;
        endcase
      end
      // a result accepted at this edge belongs to an older tick
      if (cmd_ch.valid && cmd_ch.ready) begin
        got.phase      = cmd_ch.phase;
        got.move_valid = cmd_ch.move_valid;
        got.target     = cmd_ch.target_position;
        got.speed      = cmd_ch.speed_select;
        got.accel      = cmd_ch.accel_select;
        got.force_stop = cmd_ch.force_stop;
        got.clamp      = cmd_ch.clamp_command;
        got.light      = cmd_ch.warning_light;
        got.done       = cmd_ch.cycle_done;
        if (expected_cmds.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] command item with no tick outstanding", $realtime);
        end else begin
          want = expected_cmds.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("[%0t] command %0d mismatch", $realtime, checked);
              $display("exp ph=%0d mv=%0b tgt=%0d spd=%0d acc=%0b fs=%0b cl=%0d lt=%0b dn=%0b",
                       want.phase, want.move_valid, want.target, want.speed, want.accel,
                       want.force_stop, want.clamp, want.light, want.done);
              $display("got ph=%0d mv=%0b tgt=%0d spd=%0d acc=%0b fs=%0b cl=%0d lt=%0b dn=%0b",
                       got.phase, got.move_valid, got.target, got.speed, got.accel,
                       got.force_stop, got.clamp, got.light, got.done);
            end
          end
          checked++;
        end
      end
      if (tick_ch.valid && tick_ch.ready) begin
        advance_tick(tick_ch.cycle_enter, tick_ch.now_ms, tick_ch.start_pressed,
                     tick_ch.motor_running, tick_ch.motor_position, tick_ch.random_draw,
                     want);
        expected_cmds.push_back(want);
      end
      pending = expected_cmds.size();
    end
  end

endmodule

@@ dv/tb_cut_cycle_motion_sequencer.sv @@
// ----------------------------------------------------------------------------
// tb_cut_cycle_motion_sequencer
// Drives control ticks and register settings into the cut-cycle sequencer
// and gives the verdict; a separate checker predicts and compares every
// command item. A short directed cycle set is followed by random cycles
// under changing settings, random idling on both sides and one long stall.
// ----------------------------------------------------------------------------
module tb_cut_cycle_motion_sequencer;
  import ccms_pkg::*;

  localparam int CFG_W           = POSITION_BITS_DEF - 1;
  localparam int ITEMS_PER_PHASE = 250;
  localparam int SETTLE_CYCLES   = 40;
  localparam int HOLD_CYCLES     = 400;
  localparam int STALL_LIMIT     = 4000;

  typedef enum int {
    SET_DIRECTED, SET_ZERO, SET_NARROW, SET_WIDE_SPAN, SET_FULL, SET_INVERTED, SET_RANDOM
  } setting_e;

  logic             clk_i, rst_ni;
  logic             cfg_we;
  cfg_idx_e         cfg_idx;
  logic [CFG_W-1:0] cfg_data;

  ccms_in_if  tick_ch ();
  ccms_out_if cmd_ch ();

  int fail_count, pending, checked, cycles_done, estops, releases;
  int ticks_sent;
  int send_idle_pct, recv_idle_pct;
  logic hold_req;
  logic [31:0] tick_ms;
  logic [22:0] release_cfg;

  setting_e plan [6] = '{SET_ZERO, SET_NARROW, SET_WIDE_SPAN, SET_FULL,
                         SET_INVERTED, SET_RANDOM};

  cut_cycle_motion_sequencer uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (tick_ch),
    .out_if     (cmd_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  cut_cycle_checker chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tick_ch       (tick_ch),
    .cmd_ch        (cmd_ch),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .checked_o     (checked),
    .cycles_done_o (cycles_done),
    .estops_o      (estops),
    .releases_o    (releases)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic send_tick(input logic enter, input logic [31:0] now, input logic pressed,
                           input logic running, input logic [23:0] pos,
                           input logic [15:0] draw);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      tick_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    tick_ch.cycle_enter    <= enter;
    tick_ch.now_ms         <= now;
    tick_ch.start_pressed  <= pressed;
    tick_ch.motor_running  <= running;
    tick_ch.motor_position <= pos;
    tick_ch.random_draw    <= draw;
    tick_ch.valid          <= 1'b1;
    do @(posedge clk_i); while (!tick_ch.ready);
    ticks_sent++;
    @(negedge clk_i);
  endtask

  task automatic random_tick();
    logic [31:0] rnd, draw;
    logic [23:0] pos;
    if ($urandom_range(0, 99) < 3) tick_ms = tick_ms + $urandom;
    else tick_ms = tick_ms + $urandom_range(0, 3);
    // mostly close to the early release threshold
    if ($urandom_range(0, 2) == 0) begin
      rnd = $urandom;
      pos = rnd[23:0];
    end else begin
      rnd = $urandom_range(0, 16);
      pos = {1'b0, release_cfg} + rnd[23:0] - 24'd8;
    end
    draw = $urandom;
    send_tick($urandom_range(0, 99) < 40, tick_ms, $urandom_range(0, 99) < 4,
              $urandom_range(0, 99) < 65, pos, draw[15:0]);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk_i);
  endtask

  task automatic reconfigure(input setting_e kind);
    logic [31:0] r [8];
    tick_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    foreach (r[i]) r[i] = $urandom;
    case (kind)
      SET_DIRECTED: begin
        r = '{100, 2000, 5000, 4000, 3000, 0, 5, 3};
      end
      SET_ZERO: begin
        r = '{0, 0, 0, 0, 0, 0, 0, 0};
      end
      SET_FULL: begin
        r = '{23'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF,
              16'hFFFF, 16'hFFFF};
      end
      SET_NARROW: begin
        r[3] = r[2][22:0] + $urandom_range(0, 1000);
        r[4] = r[2][22:0] + $urandom_range(0, 500);
        r[6] = $urandom_range(0, 40);
        r[7] = $urandom_range(0, 20);
      end
      SET_WIDE_SPAN: begin
        r[2] = 0;
        r[3] = 23'h7FFFFF;
        r[6] = $urandom_range(0, 200);
        r[7] = $urandom_range(0, 60);
      end
      SET_INVERTED: begin
        r[2] = $urandom_range(1, 23'h7FFFFF);
        r[3] = $urandom_range(0, r[2] - 1);
        r[6] = 1;
        r[7] = 1;
      end
      default: ;
    endcase
    write_reg(CFG_APPROACH,     r[0][22:0]);
    write_reg(CFG_CUTTING,      r[1][22:0]);
    write_reg(CFG_DROPOFF_MIN,  r[2][22:0]);
    write_reg(CFG_DROPOFF_MAX,  r[3][22:0]);
    write_reg(CFG_EARLY_REL,    r[4][22:0]);
    write_reg(CFG_HOME,         r[5][22:0]);
    write_reg(CFG_ESTOP_DELAY,  {7'd0, r[6][15:0]});
    write_reg(CFG_DROPOFF_WAIT, {7'd0, r[7][15:0]});
    cfg_we      <= 1'b0;
    release_cfg = r[4][22:0];
    @(negedge clk_i);
  endtask

  // output side: random stalls, plus one long hold-off on request
  initial begin : receiver
    int   hold_left;
    logic hold_used;
    hold_left = 0;
    hold_used = 1'b0;
    cmd_ch.ready <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_used) begin
        hold_used = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        cmd_ch.ready <= 1'b0;
      end else begin
        cmd_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((tick_ch.valid && tick_ch.ready) || (cmd_ch.valid && cmd_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("timeout: no item moved for %0d cycles, %0d commands pending",
             STALL_LIMIT, pending);
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    rst_ni                 = 1'b0;
    cfg_we                 = 1'b0;
    cfg_idx                = CFG_APPROACH;
    cfg_data               = '0;
    hold_req               = 1'b0;
    tick_ch.valid          = 1'b0;
    tick_ch.cycle_enter    = 1'b0;
    tick_ch.now_ms         = '0;
    tick_ch.start_pressed  = 1'b0;
    tick_ch.motor_running  = 1'b0;
    tick_ch.motor_position = '0;
    tick_ch.random_draw    = '0;
    send_idle_pct          = 21;
    recv_idle_pct          = 46;
    ticks_sent             = 0;
    release_cfg            = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    reconfigure(SET_DIRECTED);
    // idle without enter, press ignored
    send_tick(1'b0, 32'h0000_0000, 1'b1, 1'b1, 24'h000000, 16'h0000);
    // full cycle across the timestamp wrap, max below min on the pick
    send_tick(1'b1, 32'hFFFF_FFFE, 1'b1, 1'b1, 24'h800000, 16'hFFFF);
    send_tick(1'b0, 32'hFFFF_FFFF, 1'b0, 1'b0, 24'h000000, 16'h0000);
    send_tick(1'b0, 32'h0000_0000, 1'b0, 1'b1, 24'h000000, 16'h0000);
    send_tick(1'b0, 32'h0000_0001, 1'b0, 1'b0, 24'h000000, 16'h0000);
    send_tick(1'b0, 32'h0000_0002, 1'b0, 1'b1, 24'd2999,   16'hFFFF);
    send_tick(1'b0, 32'h0000_0003, 1'b0, 1'b1, 24'd3000,   16'h1234);
    send_tick(1'b0, 32'h0000_0004, 1'b0, 1'b0, 24'h7FFFFF, 16'h0000);
    send_tick(1'b0, 32'h0000_0007, 1'b0, 1'b0, 24'h7FFFFF, 16'h0000);
    send_tick(1'b0, 32'h0000_0008, 1'b0, 1'b1, 24'h000000, 16'h0000);
    send_tick(1'b0, 32'h0000_0009, 1'b0, 1'b0, 24'h000000, 16'h0000);
    // press at exactly the delay, then just past it during approach
    send_tick(1'b1, 32'd100, 1'b0, 1'b1, 24'h000000, 16'h0000);
    send_tick(1'b0, 32'd105, 1'b1, 1'b1, 24'h000000, 16'h0000);
    send_tick(1'b0, 32'd106, 1'b1, 1'b1, 24'h000000, 16'h0000);
    send_tick(1'b0, 32'd107, 1'b1, 1'b0, 24'h000000, 16'h0000);
    // dropoff wait that starts at timestamp zero, then stop during return
    send_tick(1'b1, 32'hFFFF_FFF0, 1'b0, 1'b0, 24'h000000, 16'h8000);
    send_tick(1'b0, 32'hFFFF_FFF5, 1'b0, 1'b0, 24'h000000, 16'h8000);
    send_tick(1'b0, 32'h0000_0000, 1'b0, 1'b0, 24'hFFFFFB, 16'h8000);
    send_tick(1'b0, 32'h0000_0002, 1'b0, 1'b0, 24'hFFFFFB, 16'h0000);
    send_tick(1'b0, 32'h0000_0003, 1'b0, 1'b0, 24'hFFFFFB, 16'h0000);
    send_tick(1'b0, 32'h0000_0004, 1'b1, 1'b1, 24'h000000, 16'h0000);
    send_tick(1'b0, 32'h0000_0005, 1'b1, 1'b0, 24'h000000, 16'h0000);
    send_tick(1'b0, 32'h0000_0006, 1'b1, 1'b0, 24'h000000, 16'h0000);

    tick_ms = $urandom;
    for (int p = 0; p < 6; p++) begin
      if (p == 2) begin
        send_idle_pct <= 46;
        recv_idle_pct <= 21;
      end
      if (p == 4) begin
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
      end
      reconfigure(plan[p]);
      if (plan[p] == SET_WIDE_SPAN) tick_ms = 32'hFFFF_FF80;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (p == 1 && n == 60) hold_req <= 1'b1;
        random_tick();
      end
    end

    tick_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    $display("covered %0d ticks and %0d commands over 7 register settings",
             ticks_sent, checked);
    $display("  %0d cycles ended, %0d emergency stops, %0d early clamp releases",
             cycles_done, estops, releases);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
